>>> design/lcbe_pkg.sv
// ----------------------------------------------------------------------------
// lcbe_pkg
// Shared types, constants and the brightness table for the LED chain
// bitstream encoder.
// ----------------------------------------------------------------------------
package lcbe_pkg;

    localparam int PULSE_W            = 16;
    localparam int COLOR_W            = 8;
    localparam int LEVEL_W            = 6;
    localparam int AMOUNT_W           = 8;
    localparam int GAP_W              = 7;
    localparam int PIXEL_BITS         = 24;
    localparam int GAP_LIMIT          = 64;
    localparam int TABLE_TOP          = 45;
    localparam int TAN_W              = 17;
    localparam int REM_W              = 6;
    localparam int CFG_IDX_W          = 2;
    localparam int CFG_DATA_W         = 16;
    localparam int QUEUE_DEPTH        = 2;
    localparam int QPTR_W             = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W             = $clog2(QUEUE_DEPTH + 1);

    localparam int DEFAULT_CODE_WIDTH = 16;
    localparam int DEFAULT_MAX_LEVEL  = 45;

    localparam int ONE_CODE_RESET     = 60;
    localparam int ZERO_CODE_RESET    = 30;
    localparam int GAP_SLOTS_RESET    = 50;

    localparam logic [CFG_IDX_W-1:0] CFG_ONE_CODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_CODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_SLOTS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALING   = 2'd3;

    typedef enum logic [1:0] {
        KIND_GAP   = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_FADE  = 2'd2,
        KIND_LEVEL = 2'd3
    } kind_t;

    typedef struct packed {
        logic                  pixel;
        logic [REM_W-1:0]      rem;
        logic [PIXEL_BITS-1:0] word;
    } item_t;

    // tan(level degrees) in Q1.16, rounded to nearest; levels above the
    // table give full brightness.
    function automatic logic [TAN_W-1:0] tan_q16(input logic [LEVEL_W-1:0] lvl);
        logic [TAN_W-1:0] v;
        case (lvl)
            6'd0:  v = 17'd0;
            6'd1:  v = 17'd1144;
            6'd2:  v = 17'd2289;
            6'd3:  v = 17'd3435;
            6'd4:  v = 17'd4583;
            6'd5:  v = 17'd5734;
            6'd6:  v = 17'd6888;
            6'd7:  v = 17'd8047;
            6'd8:  v = 17'd9210;
            6'd9:  v = 17'd10380;
            6'd10: v = 17'd11556;
            6'd11: v = 17'd12739;
            6'd12: v = 17'd13930;
            6'd13: v = 17'd15130;
            6'd14: v = 17'd16340;
            6'd15: v = 17'd17560;
            6'd16: v = 17'd18792;
            6'd17: v = 17'd20036;
            6'd18: v = 17'd21294;
            6'd19: v = 17'd22566;
            6'd20: v = 17'd23853;
            6'd21: v = 17'd25157;
            6'd22: v = 17'd26478;
            6'd23: v = 17'd27818;
            6'd24: v = 17'd29179;
            6'd25: v = 17'd30560;
            6'd26: v = 17'd31964;
            6'd27: v = 17'd33392;
            6'd28: v = 17'd34846;
            6'd29: v = 17'd36327;
            6'd30: v = 17'd37837;
            6'd31: v = 17'd39378;
            6'd32: v = 17'd40951;
            6'd33: v = 17'd42560;
            6'd34: v = 17'd44205;
            6'd35: v = 17'd45889;
            6'd36: v = 17'd47615;
            6'd37: v = 17'd49385;
            6'd38: v = 17'd51202;
            6'd39: v = 17'd53070;
            6'd40: v = 17'd54991;
            6'd41: v = 17'd56970;
            6'd42: v = 17'd59009;
            6'd43: v = 17'd61113;
            6'd44: v = 17'd63287;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

>>> design/lcbe_front.sv
// ----------------------------------------------------------------------------
// lcbe_front
// Accepts input beats, keeps the fade and brightness state, scales and packs
// pixels and hands gap and pixel jobs to the queue.
// ----------------------------------------------------------------------------
module lcbe_front #(
    parameter int MAX_LEVEL = lcbe_pkg::DEFAULT_MAX_LEVEL
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      kind,
    input  logic [lcbe_pkg::COLOR_W-1:0]    green,
    input  logic [lcbe_pkg::COLOR_W-1:0]    red,
    input  logic [lcbe_pkg::COLOR_W-1:0]    blue,
    input  logic [lcbe_pkg::AMOUNT_W-1:0]   amount,
    input  logic                            scaling_enable,
    input  logic [lcbe_pkg::GAP_W-1:0]      gap_slots,
    input  logic                            q_ready,
    output logic                            q_push,
    output lcbe_pkg::item_t                 q_item
);
    import lcbe_pkg::*;

    localparam logic [LEVEL_W-1:0]  MAX_LVL  = LEVEL_W'(MAX_LEVEL);
    localparam logic signed [9:0]   MAX_T    = 10'(MAX_LEVEL);

    logic [LEVEL_W-1:0]  fade_level_reg,    fade_level_next;
    logic                fade_falling_reg,  fade_falling_next;
    logic [LEVEL_W-1:0]  applied_level_reg, applied_level_next;

    logic                accept;
    logic [LEVEL_W-1:0]  lvl;
    logic [TAN_W-1:0]    gain;
    logic [24:0]         prod_g;
    logic [24:0]         prod_r;
    logic [24:0]         prod_b;
    logic [COLOR_W-1:0]  g_s;
    logic [COLOR_W-1:0]  r_s;
    logic [COLOR_W-1:0]  b_s;
    logic [GAP_W-1:0]    gap_m1;
    logic [REM_W-1:0]    gap_rem;
    logic signed [9:0]   t;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;

    always_comb
    begin
        lvl    = (applied_level_reg > LEVEL_W'(TABLE_TOP)) ? LEVEL_W'(TABLE_TOP)
                                                          : applied_level_reg;
        gain   = tan_q16(lvl);
        prod_g = 25'(green) * 25'(gain);
        prod_r = 25'(red)   * 25'(gain);
        prod_b = 25'(blue)  * 25'(gain);
        g_s    = scaling_enable ? prod_g[23:16] : green;
        r_s    = scaling_enable ? prod_r[23:16] : red;
        b_s    = scaling_enable ? prod_b[23:16] : blue;

        gap_m1 = gap_slots - GAP_W'(1);
        if (gap_slots == '0)
        begin
            gap_rem = '0;
        end
        else if (gap_slots > GAP_W'(GAP_LIMIT))
        begin
            gap_rem = REM_W'(GAP_LIMIT - 1);
        end
        else
        begin
            gap_rem = gap_m1[REM_W-1:0];
        end

        if (fade_falling_reg)
        begin
            t = $signed({4'b0, fade_level_reg}) - $signed({2'b0, amount});
        end
        else
        begin
            t = $signed({4'b0, fade_level_reg}) + $signed({2'b0, amount});
        end
    end

    always_comb
    begin
        fade_level_next    = fade_level_reg;
        fade_falling_next  = fade_falling_reg;
        applied_level_next = applied_level_reg;
        q_push             = 1'b0;
        q_item.pixel       = 1'b0;
        q_item.rem         = gap_rem;
        q_item.word        = {g_s, r_s, b_s};

        if (accept)
        begin
            unique case (kind_t'(kind))
                KIND_GAP:
                begin
                    q_push = 1'b1;
                end
                KIND_PIXEL:
                begin
                    q_push       = 1'b1;
                    q_item.pixel = 1'b1;
                    q_item.rem   = REM_W'(PIXEL_BITS - 1);
                end
                KIND_FADE:
                begin
                    if (t >= MAX_T || t <= 10'sd0)
                    begin
                        fade_falling_next = !fade_falling_reg;
                    end
                    if (t > MAX_T)
                    begin
                        fade_level_next = MAX_LVL;
                    end
                    else if (t < 10'sd0)
                    begin
                        fade_level_next = '0;
                    end
                    else
                    begin
                        fade_level_next = t[LEVEL_W-1:0];
                    end
                    applied_level_next = fade_level_next;
                end
                KIND_LEVEL:
                begin
                    applied_level_next = (amount > AMOUNT_W'(MAX_LEVEL)) ? MAX_LVL
                                                                      : amount[LEVEL_W-1:0];
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_level_reg    <= MAX_LVL;
            fade_falling_reg  <= 1'b1;
            applied_level_reg <= MAX_LVL;
        end
        else
        begin
            fade_level_reg    <= fade_level_next;
            fade_falling_reg  <= fade_falling_next;
            applied_level_reg <= applied_level_next;
        end
    end

endmodule

>>> design/lcbe_queue.sv
// ----------------------------------------------------------------------------
// lcbe_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module lcbe_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lcbe_pkg::item_t  push_item,
    output logic             push_ready,
    input  logic             pop,
    output logic             pop_valid,
    output lcbe_pkg::item_t  pop_item
);
    import lcbe_pkg::*;

    item_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg,  count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> design/lcbe_back.sv
// ----------------------------------------------------------------------------
// lcbe_back
// Takes jobs from the queue and emits one duty code per bit slot into the
// output register.
// ----------------------------------------------------------------------------
module lcbe_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  lcbe_pkg::item_t               q_item,
    output logic                          q_pop,
    input  logic [lcbe_pkg::PULSE_W-1:0]  one_code,
    input  logic [lcbe_pkg::PULSE_W-1:0]  zero_code,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lcbe_pkg::PULSE_W-1:0]  pulse_code,
    output logic                          last_of_run
);
    import lcbe_pkg::*;

    logic                   busy_reg;
    logic                   pixel_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [PIXEL_BITS-1:0]  word_reg;
    logic                   out_valid_reg;
    logic [PULSE_W-1:0]     pulse_code_reg;
    logic                   last_reg;

    logic                   advance;
    logic                   finish;

    assign advance     = busy_reg && (!out_valid_reg || out_ready);
    assign finish      = advance && (rem_reg == '0);
    assign q_pop       = q_valid && (!busy_reg || finish);
    assign out_valid   = out_valid_reg;
    assign pulse_code  = pulse_code_reg;
    assign last_of_run = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                busy_reg <= 1'b1;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            pixel_reg <= q_item.pixel;
            rem_reg   <= q_item.rem;
            word_reg  <= q_item.word;
        end
        else if (advance)
        begin
            rem_reg  <= rem_reg - REM_W'(1);
            word_reg <= {word_reg[PIXEL_BITS-2:0], 1'b0};
        end

        if (advance)
        begin
            if (!pixel_reg)
            begin
                pulse_code_reg <= '0;
            end
            else if (word_reg[PIXEL_BITS-1])
            begin
                pulse_code_reg <= one_code;
            end
            else
            begin
                pulse_code_reg <= zero_code;
            end
            last_reg <= (rem_reg == '0);
        end
    end

endmodule

>>> design/led_chain_bitstream_encoder.sv
// ----------------------------------------------------------------------------
// led_chain_bitstream_encoder
// The first code of an item passes from the queue slot into the back end's job
// registers and then into the output register.
// Throughput: one code per cycle while out_ready is high; a pixel gives 24
// codes, a gap one code per slot (at least one, at most 64), counted by the
// single output slot counter in the back end. Fade and level items give no
// output. Reset empties the queue and the output register and returns the
// fade state and the configuration registers to their reset values.
// ----------------------------------------------------------------------------
module led_chain_bitstream_encoder #(
    parameter int CODE_WIDTH = lcbe_pkg::DEFAULT_CODE_WIDTH,
    parameter int MAX_LEVEL  = lcbe_pkg::DEFAULT_MAX_LEVEL
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lcbe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lcbe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       kind,
    input  logic [lcbe_pkg::COLOR_W-1:0]     green,
    input  logic [lcbe_pkg::COLOR_W-1:0]     red,
    input  logic [lcbe_pkg::COLOR_W-1:0]     blue,
    input  logic [lcbe_pkg::AMOUNT_W-1:0]    amount,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [lcbe_pkg::PULSE_W-1:0]     pulse_code,
    output logic                             last_of_run
);
    import lcbe_pkg::*;

    localparam int CW = (CODE_WIDTH < PULSE_W) ? CODE_WIDTH : PULSE_W;

    logic [CW-1:0]     one_code_reg;
    logic [CW-1:0]     zero_code_reg;
    logic [GAP_W-1:0]  gap_slots_reg;
    logic              scaling_reg;

    logic              q_ready;
    logic              q_push;
    item_t             push_item;
    logic              q_valid;
    logic              q_pop;
    item_t             pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_code_reg  <= CW'(ONE_CODE_RESET);
            zero_code_reg <= CW'(ZERO_CODE_RESET);
            gap_slots_reg <= GAP_W'(GAP_SLOTS_RESET);
            scaling_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ONE_CODE:  one_code_reg  <= cfg_data[CW-1:0];
                CFG_ZERO_CODE: zero_code_reg <= cfg_data[CW-1:0];
                CFG_GAP_SLOTS: gap_slots_reg <= cfg_data[GAP_W-1:0];
                CFG_SCALING:   scaling_reg   <= cfg_data[0];
                default:       scaling_reg   <= scaling_reg;
            endcase
        end
    end

    lcbe_front #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .green          (green),
        .red            (red),
        .blue           (blue),
        .amount         (amount),
        .scaling_enable (scaling_reg),
        .gap_slots      (gap_slots_reg),
        .q_ready        (q_ready),
        .q_push         (q_push),
        .q_item         (push_item)
    );

    lcbe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (push_item),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_item   (pop_item)
    );

    lcbe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (pop_item),
        .q_pop       (q_pop),
        .one_code    (PULSE_W'(one_code_reg)),
        .zero_code   (PULSE_W'(zero_code_reg)),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pulse_code  (pulse_code),
        .last_of_run (last_of_run)
    );

endmodule

>>> design/lcbe_checker.sv
// ----------------------------------------------------------------------------
// lcbe_checker
// Port-level checks for the LED chain bitstream encoder, bound to the top.
// ----------------------------------------------------------------------------
module lcbe_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [lcbe_pkg::PULSE_W-1:0]     pulse_code,
    input  logic                             last_of_run
);

    // A stalled output beat must hold its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pulse_code)
                                    && $stable(last_of_run))
        else $error("output beat changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid after a reset edge");

    // Nothing can be emitted straight after reset.
    a_no_early_out: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid straight after reset");

    // Reset empties the queue, so input is taken after a reset edge.
    a_ready_in_reset: assert property (@(posedge clk)
        !rst_n |=> in_ready)
        else $error("input not ready while queue is empty");

    // A new output beat must follow an earlier input valid, input ready or output valid.
    a_out_needs_in: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid, 2) || $past(out_valid, 1)
                             || $past(in_valid, 3) || $past(in_ready, 2))
        else $error("output appeared without input");

endmodule

bind led_chain_bitstream_encoder lcbe_checker u_lcbe_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pulse_code  (pulse_code),
    .last_of_run (last_of_run)
);
